@@ src/u8u16_pkg.sv @@
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

    // largest unit count one string may ever produce, whatever the register holds
    localparam int unsigned MAX_OUT_UNITS = 65536;

    localparam logic [16:0] CAP_RESET  = 17'd65536;
    localparam logic [20:0] CP_BMP_MAX = 21'h00FFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_string;
        logic [16:0] units_written;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic drain;
    } t_cmd;

    typedef struct packed {
        logic step_final;
        logic res_any;
        logic drain_last;
        logic out_free;
    } t_status;

endpackage

@@ src/utf8_to_utf16_transcoder_top.sv @@
// top level of the utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per input transfer, with a flag on the string's last byte, and
// gives UTF-16 code units, one per output transfer; code points above 0xFFFF come out as a
// surrogate pair. Continuation bytes are used by their low six bits without checking,
// overlong forms pass, bad lead bytes are dropped, and a four-byte form above 0x10FFFF
// drops only its lead while the three bytes after it are decoded again as leads. A
// sequence still open at the last byte is dropped. Once a character would exceed the
// capacity register (17 bits, reset 65536, clamped to 65536) nothing more of the string
// is written. The string's final result carries end_of_string and the unit count; if the
// last byte gives no unit, a result with has_unit low is sent as the end marker. An item is
// taken while the block is idle, then the decode step handles one byte per cycle (one byte,
// or four after an out-of-range four-byte form), then each result of the item moves from a
// three-entry buffer into the output register whenever that register is free. The next byte
// is taken only once all results have left the buffer, but while the last result still
// waits in the output register. Capacity writes belong between strings or while the block
// is idle.
module utf8_to_utf16_transcoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel: one utf-8 byte per transfer
    input  logic                 i_valid,
    output logic                 o_ready,
    input  u8u16_pkg::t_in_item  i_in,
    // output channel: one utf-16 unit or end marker per transfer
    output logic                 o_valid,
    input  logic                 i_ready,
    output u8u16_pkg::t_out_item o_out,
    // capacity register write
    input  logic                 i_cfg_we,
    input  logic [16:0]          i_cfg_data
);
    import u8u16_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing: load, decode steps, drain
    u8u16_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // decode state, result buffer and output register
    u8u16_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_out_ready (i_ready),
        .o_status    (w_status),
        .o_out       (o_out),
        .o_out_valid (o_valid)
    );

`ifndef ASSERT_OFF
    // a result is only moved into the output register when it can take it
    a_drain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drain |-> w_status.out_free)
        else $error("drain while output register busy");

    // an accepted byte is decoded in the next cycle
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.step)
        else $error("accepted byte not decoded");

    // a result without a unit is always a clean end marker
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.has_unit) |-> (o_out.end_of_string && (o_out.code_unit == 16'd0)))
        else $error("malformed end marker");
`endif

endmodule

@@ src/u8u16_ctrl.sv @@
// controller state machine of the utf-8 to utf-16 transcoder
module u8u16_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  u8u16_pkg::t_status i_status,
    output logic              o_ready,
    output u8u16_pkg::t_cmd    o_cmd
);
    import u8u16_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_status.step_final) begin
                    n_state = i_status.res_any ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.drain = 1'b1;
                    if (i_status.drain_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/u8u16_datapath.sv @@
// decode datapath, result buffer and output register of the utf-8 to utf-16 transcoder
module u8u16_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [16:0]          i_cfg_data,
    input  u8u16_pkg::t_in_item  i_in,
    input  u8u16_pkg::t_cmd      i_cmd,
    input  logic                 i_out_ready,
    output u8u16_pkg::t_status   o_status,
    output u8u16_pkg::t_out_item o_out,
    output logic                 o_out_valid
);
    import u8u16_pkg::*;

    // configuration and per-string state
    logic [16:0] r_cap;
    logic [7:0]  r_held [3];
    logic [1:0]  r_held_cnt;
    logic [2:0]  r_seq_len;
    logic [16:0] r_unit_cnt;
    logic        r_stopped;
    // bytes waiting for the decode step
    logic [7:0]  r_q [3];
    logic [1:0]  r_q_cnt;
    logic        r_last;
    // results of the current item
    t_out_item   r_res [3];
    logic [1:0]  r_res_cnt;
    logic [1:0]  r_rd;
    t_out_item   r_out;
    logic        r_out_valid;

    logic [7:0]  n_held [3];
    logic [1:0]  n_held_cnt;
    logic [2:0]  n_seq_len;
    logic [16:0] n_unit_cnt;
    logic        n_stopped;
    logic [7:0]  n_q [3];
    logic [1:0]  n_q_cnt;
    logic        n_last;
    t_out_item   n_res [3];
    logic [1:0]  n_res_cnt;
    logic [1:0]  n_rd;

    logic [7:0]  w_x;
    logic [16:0] w_cap;
    logic [17:0] w_cnt_p1;
    logic [17:0] w_cnt_p2;
    logic [20:0] w_cp;
    logic [20:0] w_v;
    logic        w_complete;
    logic        w_rescan;
    logic        w_final;
    logic [1:0]  w_nadd;
    logic [1:0]  w_newcnt;
    t_out_item   w_e0;
    t_out_item   w_e1;
    logic [7:0]  d_held [3];
    logic [1:0]  d_held_cnt;
    logic [2:0]  d_seq_len;
    logic [16:0] d_unit_cnt;
    logic        d_stopped;

    assign w_x      = r_q[0];
    assign w_cap    = ({15'd0, r_cap} > MAX_OUT_UNITS) ? MAX_OUT_UNITS[16:0] : r_cap;
    assign w_cnt_p1 = {1'b0, r_unit_cnt} + 18'd1;
    assign w_cnt_p2 = {1'b0, r_unit_cnt} + 18'd2;
    assign w_v      = w_cp - SUPP_BASE;

    // one byte of decode
    always_comb begin
        d_held     = r_held;
        d_held_cnt = r_held_cnt;
        d_seq_len  = r_seq_len;
        d_unit_cnt = r_unit_cnt;
        d_stopped  = r_stopped;
        w_cp       = '0;
        w_complete = 1'b0;
        w_rescan   = 1'b0;
        w_nadd     = 2'd0;
        w_e0       = '0;
        w_e1       = '0;
        if (!r_stopped) begin
            if (r_seq_len == 3'd0) begin
                if (!w_x[7]) begin
                    w_cp       = {13'd0, w_x};
                    w_complete = 1'b1;
                end else if (w_x[7:5] == 3'b110) begin
                    d_seq_len  = 3'd2;
                    d_held[0]  = w_x;
                    d_held_cnt = 2'd1;
                end else if (w_x[7:4] == 4'b1110) begin
                    d_seq_len  = 3'd3;
                    d_held[0]  = w_x;
                    d_held_cnt = 2'd1;
                end else if (w_x[7:3] == 5'b11110) begin
                    d_seq_len  = 3'd4;
                    d_held[0]  = w_x;
                    d_held_cnt = 2'd1;
                end
            end else if (({1'b0, r_held_cnt} + 3'd1) < r_seq_len) begin
                d_held[r_held_cnt] = w_x;
                d_held_cnt         = r_held_cnt + 2'd1;
            end else begin
                unique case (r_seq_len)
                    3'd2:    w_cp = {10'd0, r_held[0][4:0], w_x[5:0]};
                    3'd3:    w_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], w_x[5:0]};
                    default: w_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], w_x[5:0]};
                endcase
                d_seq_len  = 3'd0;
                d_held_cnt = 2'd0;
                w_complete = 1'b1;
            end
            if (w_complete) begin
                if (w_cp <= CP_BMP_MAX) begin
                    if (w_cnt_p1 > {1'b0, w_cap}) begin
                        d_stopped = 1'b1;
                    end else begin
                        w_nadd     = 2'd1;
                        w_e0       = '{w_cp[15:0], 1'b1, 1'b0, w_cnt_p1[16:0]};
                        d_unit_cnt = w_cnt_p1[16:0];
                    end
                end else if (w_cp <= CP_MAX) begin
                    if (w_cnt_p2 > {1'b0, w_cap}) begin
                        d_stopped = 1'b1;
                    end else begin
                        w_nadd     = 2'd2;
                        w_e0       = '{HI_SURR + {6'd0, w_v[19:10]}, 1'b1, 1'b0,
                                       w_cnt_p1[16:0]};
                        w_e1       = '{LO_SURR + {6'd0, w_v[9:0]}, 1'b1, 1'b0,
                                       w_cnt_p2[16:0]};
                        d_unit_cnt = w_cnt_p2[16:0];
                    end
                end else begin
                    w_rescan = 1'b1;
                end
            end
        end
    end

    assign w_final  = !w_rescan && (r_q_cnt == 2'd1);
    assign w_newcnt = r_res_cnt + w_nadd;

    assign o_status.step_final = w_final;
    assign o_status.res_any    = (w_newcnt != 2'd0) || r_last;
    assign o_status.drain_last = (r_rd == (r_res_cnt - 2'd1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_seq_len  = r_seq_len;
        n_unit_cnt = r_unit_cnt;
        n_stopped  = r_stopped;
        n_q        = r_q;
        n_q_cnt    = r_q_cnt;
        n_last     = r_last;
        n_res      = r_res;
        n_res_cnt  = r_res_cnt;
        n_rd       = r_rd;
        if (i_cmd.load) begin
            n_q[0]  = i_in.byte_in;
            n_q_cnt = 2'd1;
            n_last  = i_in.last_byte;
        end
        if (i_cmd.step) begin
            n_held     = d_held;
            n_held_cnt = d_held_cnt;
            n_seq_len  = d_seq_len;
            n_unit_cnt = d_unit_cnt;
            n_stopped  = d_stopped;
            if (w_rescan) begin
                // the two held continuation bytes and this one come back as leads
                n_q[0]  = r_held[1];
                n_q[1]  = r_held[2];
                n_q[2]  = w_x;
                n_q_cnt = 2'd3;
            end else begin
                n_q[0]  = r_q[1];
                n_q[1]  = r_q[2];
                n_q_cnt = r_q_cnt - 2'd1;
            end
            if (w_nadd != 2'd0) begin
                n_res[r_res_cnt] = w_e0;
            end
            if (w_nadd == 2'd2) begin
                n_res[r_res_cnt + 2'd1] = w_e1;
            end
            n_res_cnt = w_newcnt;
            if (w_final && r_last) begin
                if (w_newcnt == 2'd0) begin
                    n_res[0]  = '{16'd0, 1'b0, 1'b1, r_unit_cnt};
                    n_res_cnt = 2'd1;
                end else begin
                    n_res[w_newcnt - 2'd1].end_of_string = 1'b1;
                end
                n_held     = '{8'd0, 8'd0, 8'd0};
                n_held_cnt = 2'd0;
                n_seq_len  = 3'd0;
                n_unit_cnt = 17'd0;
                n_stopped  = 1'b0;
            end
        end
        if (i_cmd.drain) begin
            if (o_status.drain_last) begin
                n_rd      = 2'd0;
                n_res_cnt = 2'd0;
            end else begin
                n_rd = r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_held_cnt  <= 2'd0;
            r_seq_len   <= 3'd0;
            r_unit_cnt  <= 17'd0;
            r_stopped   <= 1'b0;
            r_q_cnt     <= 2'd0;
            r_last      <= 1'b0;
            r_res_cnt   <= 2'd0;
            r_rd        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
            r_unit_cnt <= n_unit_cnt;
            r_stopped  <= n_stopped;
            r_q_cnt    <= n_q_cnt;
            r_last     <= n_last;
            r_res_cnt  <= n_res_cnt;
            r_rd       <= n_rd;
            if (i_cmd.drain) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_q    <= n_q;
        r_res  <= n_res;
        if (i_cmd.drain) begin
            r_out <= r_res[r_rd];
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule
